// ===== design/assert_macros.svh =====
// Assertion macros used by the solver top.
// Depends on nothing; users supply clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CHECK_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
`define CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`else
`define CHECK_IMPLY(lbl, ante, cons)
`define CHECK_NEXT(lbl, ante, cons)
`endif
`endif

// ===== design/fbps_pkg.sv =====
// Package for the four-bar position solver: widths, latencies, codes, atan table.
// Used by every module of the block.
package fbps_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;

    localparam int LEN_W     = 16;
    localparam int ANG_IN_W  = 17;
    localparam int TRANS_W   = 15;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 3;

    localparam int TURN_UNITS    = 46080;
    localparam int HALF_UNITS    = 23040;
    localparam int QUARTER_UNITS = 11520;
    localparam int ANG_FRAC      = 16;
    localparam int LEN_FRAC      = 8;
    localparam int QUARTER_Z     = 754974720;
    localparam logic [29:0] GAIN_Q30 = 30'd652032874;

    localparam int ROT_W      = 27;
    localparam int ROTZ_W     = 32;
    localparam int D_W        = 26;
    localparam int RAD_W      = 64;
    localparam int ROOT_W     = 32;
    localparam int VIN_W      = 33;
    localparam int VEC_W      = 35;
    localparam int ANG_W      = 33;
    localparam int NORM_STEPS = 5;
    localparam int NUM_W      = 54;
    localparam int DEN_W      = 53;
    localparam int DN_W       = 31;

    localparam int ISQ_LAT   = ROOT_W;
    localparam int ROT_LAT   = 2 + CORDIC_STEPS;
    localparam int VEC_LAT   = NORM_STEPS + 1 + CORDIC_STEPS;
    localparam int M_DLY     = 2 + ISQ_LAT;
    localparam int ACOS_LAT  = 1 + NORM_STEPS + 3 + ISQ_LAT + VEC_LAT;
    localparam int BETA_DLY  = 4 + ISQ_LAT + ACOS_LAT - VEC_LAT;
    localparam int FLAG_DLY  = 1 + ACOS_LAT;
    localparam int TOTAL_LAT = ROT_LAT + 5 + ISQ_LAT + ACOS_LAT + 1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FRAME   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNREACH = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DEGEN   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_CRANK   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUPLER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROCKER  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOL     = 3'd4;

    // atan(2^-i) in 2^-23 degree
    localparam logic signed [31:0] ATAN_TABLE [TABLE_LEN] = '{
        32'sd377487360, 32'sd222843801, 32'sd117744544, 32'sd59768969,
        32'sd30000467, 32'sd15014858, 32'sd7509261, 32'sd3754860,
        32'sd1877459, 32'sd938733, 32'sd469367, 32'sd234683,
        32'sd117342, 32'sd58671, 32'sd29335, 32'sd14668,
        32'sd7334, 32'sd3667, 32'sd1833, 32'sd917,
        32'sd458, 32'sd229, 32'sd115, 32'sd57
    };

endpackage

// ===== design/fbps_isqrt.sv =====
// Pipelined floor integer square root, one root bit per stage.
// Depends on fbps_pkg.
module fbps_isqrt import fbps_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [RAD_W-1:0]  n,
    output logic [ROOT_W-1:0] q
);

    logic [RAD_W-1:0]  rad_reg  [ISQ_LAT];
    logic [ROOT_W-1:0] root_reg [ISQ_LAT];
    logic [33:0]       rem_reg  [ISQ_LAT];

    for (genvar i = 0; i < ISQ_LAT; i++) begin : g_stage
        logic [RAD_W-1:0]  nin;
        logic [ROOT_W-1:0] qin;
        logic [33:0]       rin;
        logic [35:0]       rt;
        logic [35:0]       tt;
        if (i == 0) begin : g_first
            assign nin = n;
            assign qin = '0;
            assign rin = '0;
        end
        else begin : g_rest
            assign nin = rad_reg[i-1];
            assign qin = root_reg[i-1];
            assign rin = rem_reg[i-1];
        end
        assign rt = {rin, nin[RAD_W-1:RAD_W-2]};
        assign tt = {2'b00, qin, 2'b01};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[i] <= {nin[RAD_W-3:0], 2'b00};
                if (rt >= tt)
                begin
                    rem_reg[i]  <= 34'(rt - tt);
                    root_reg[i] <= {qin[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i]  <= rt[33:0];
                    root_reg[i] <= {qin[ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign q = root_reg[ISQ_LAT-1];

endmodule

// ===== design/fbps_vec_cordic.sv =====
// Pipelined vectoring CORDIC: atan2(y, x) in 2^-23 degree.
// Normalizes by left shifts, folds the left half plane, then one step per stage. Uses fbps_pkg.
module fbps_vec_cordic import fbps_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [VIN_W-1:0] y,
    input  logic signed [VIN_W-1:0] x,
    output logic signed [ANG_W-1:0] z
);

    logic signed [VEC_W-1:0] xn_reg [NORM_STEPS];
    logic signed [VEC_W-1:0] yn_reg [NORM_STEPS];
    logic                    zn_reg [NORM_STEPS];

    for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
        localparam int SH = 16 >> k;
        logic signed [VEC_W-1:0] xi;
        logic signed [VEC_W-1:0] yi;
        logic signed [VEC_W-1:0] ax;
        logic signed [VEC_W-1:0] ay;
        logic signed [VEC_W-1:0] mx;
        logic                    zi;
        if (k == 0) begin : g_first
            assign xi = VEC_W'(x);
            assign yi = VEC_W'(y);
            assign zi = (x == '0) && (y == '0);
        end
        else begin : g_rest
            assign xi = xn_reg[k-1];
            assign yi = yn_reg[k-1];
            assign zi = zn_reg[k-1];
        end
        assign ax = (xi < 0) ? -xi : xi;
        assign ay = (yi < 0) ? -yi : yi;
        assign mx = (ax > ay) ? ax : ay;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zn_reg[k] <= zi;
                if (mx < (VEC_W'(1) <<< (31 - SH)))
                begin
                    xn_reg[k] <= xi <<< SH;
                    yn_reg[k] <= yi <<< SH;
                end
                else
                begin
                    xn_reg[k] <= xi;
                    yn_reg[k] <= yi;
                end
            end
        end
    end

    logic signed [VEC_W-1:0] xv_reg [CORDIC_STEPS+1];
    logic signed [VEC_W-1:0] yv_reg [CORDIC_STEPS+1];
    logic signed [ANG_W-1:0] zv_reg [CORDIC_STEPS+1];
    logic                    zero_reg [CORDIC_STEPS+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= zn_reg[NORM_STEPS-1];
            if (xn_reg[NORM_STEPS-1] < 0)
            begin
                if (yn_reg[NORM_STEPS-1] >= 0)
                begin
                    xv_reg[0] <= yn_reg[NORM_STEPS-1];
                    yv_reg[0] <= -xn_reg[NORM_STEPS-1];
                    zv_reg[0] <= ANG_W'(QUARTER_Z);
                end
                else
                begin
                    xv_reg[0] <= -yn_reg[NORM_STEPS-1];
                    yv_reg[0] <= xn_reg[NORM_STEPS-1];
                    zv_reg[0] <= -ANG_W'(QUARTER_Z);
                end
            end
            else
            begin
                xv_reg[0] <= xn_reg[NORM_STEPS-1];
                yv_reg[0] <= yn_reg[NORM_STEPS-1];
                zv_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic signed [VEC_W-1:0] xs;
        logic signed [VEC_W-1:0] ys;
        logic signed [ANG_W-1:0] at;
        assign xs = xv_reg[i] >>> i;
        assign ys = yv_reg[i] >>> i;
        assign at = ANG_W'(ATAN_TABLE[i]);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (yv_reg[i] > 0)
                begin
                    xv_reg[i+1] <= xv_reg[i] + ys;
                    yv_reg[i+1] <= yv_reg[i] - xs;
                    zv_reg[i+1] <= zv_reg[i] + at;
                end
                else
                begin
                    xv_reg[i+1] <= xv_reg[i] - ys;
                    yv_reg[i+1] <= yv_reg[i] + xs;
                    zv_reg[i+1] <= zv_reg[i] - at;
                end
            end
        end
    end

    assign z = zero_reg[CORDIC_STEPS] ? '0 : zv_reg[CORDIC_STEPS];

endmodule

// ===== design/fbps_acos.sv =====
// Pipelined acos(num/den): scale den below 2^31, clamp, root of den^2-num^2, atan2.
// Depends on fbps_pkg, fbps_isqrt and fbps_vec_cordic.
module fbps_acos import fbps_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [NUM_W-1:0] num,
    input  logic        [DEN_W-1:0] den,
    output logic signed [ANG_W-1:0] z
);

    logic [DEN_W-1:0] m0_reg;
    logic [DEN_W-1:0] d0_reg;
    logic             neg0_reg;
    logic [NUM_W-1:0] mag;

    assign mag = (num < 0) ? NUM_W'(-num) : NUM_W'(num);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m0_reg   <= mag[DEN_W-1:0];
            d0_reg   <= den;
            neg0_reg <= num < 0;
        end
    end

    logic [DEN_W-1:0] ms_reg  [NORM_STEPS];
    logic [DEN_W-1:0] ds_reg  [NORM_STEPS];
    logic             ns_reg  [NORM_STEPS];

    for (genvar k = 0; k < NORM_STEPS; k++) begin : g_scale
        localparam int SH = 16 >> k;
        logic [DEN_W-1:0] mi;
        logic [DEN_W-1:0] di;
        logic             ni;
        if (k == 0) begin : g_first
            assign mi = m0_reg;
            assign di = d0_reg;
            assign ni = neg0_reg;
        end
        else begin : g_rest
            assign mi = ms_reg[k-1];
            assign di = ds_reg[k-1];
            assign ni = ns_reg[k-1];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ns_reg[k] <= ni;
                if (di >= (DEN_W'(1) << (30 + SH)))
                begin
                    ms_reg[k] <= mi >> SH;
                    ds_reg[k] <= di >> SH;
                end
                else
                begin
                    ms_reg[k] <= mi;
                    ds_reg[k] <= di;
                end
            end
        end
    end

    logic [DN_W-1:0] mc_reg;
    logic [DN_W-1:0] dc_reg;
    logic            nc_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dc_reg <= ds_reg[NORM_STEPS-1][DN_W-1:0];
            nc_reg <= ns_reg[NORM_STEPS-1];
            if (ms_reg[NORM_STEPS-1] > ds_reg[NORM_STEPS-1])
                mc_reg <= ds_reg[NORM_STEPS-1][DN_W-1:0];
            else
                mc_reg <= ms_reg[NORM_STEPS-1][DN_W-1:0];
        end
    end

    logic [2*DN_W-1:0] dsq;
    logic [2*DN_W-1:0] msq;
    logic [2*DN_W-1:0] dsq_reg;
    logic [2*DN_W-1:0] msq_reg;
    logic [RAD_W-1:0]  diff_reg;

    assign dsq = dc_reg * dc_reg;
    assign msq = mc_reg * mc_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dsq_reg  <= dsq;
            msq_reg  <= msq;
            diff_reg <= RAD_W'(dsq_reg - msq_reg);
        end
    end

    logic [DN_W-1:0] md_reg [M_DLY];
    logic            nd_reg [M_DLY];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            md_reg[0] <= mc_reg;
            nd_reg[0] <= nc_reg;
            for (int i = 1; i < M_DLY; i++)
            begin
                md_reg[i] <= md_reg[i-1];
                nd_reg[i] <= nd_reg[i-1];
            end
        end
    end

    logic [ROOT_W-1:0]      s;
    logic signed [VIN_W-1:0] vy;
    logic signed [VIN_W-1:0] vx;
    logic signed [VIN_W-1:0] mpos;

    fbps_isqrt u_isqrt
    (
        .clk (clk),
        .en  (en),
        .n   (diff_reg),
        .q   (s)
    );

    assign mpos = $signed(VIN_W'(md_reg[M_DLY-1]));
    assign vx   = nd_reg[M_DLY-1] ? -mpos : mpos;
    assign vy   = $signed(VIN_W'(s));

    fbps_vec_cordic u_vec
    (
        .clk (clk),
        .en  (en),
        .y   (vy),
        .x   (vx),
        .z   (z)
    );

endmodule

// ===== design/fbps_rot_cordic.sv =====
// Crank pin placement: angle reduction, quadrant fold, gain prescale, rotation CORDIC.
// Depends on fbps_pkg.
module fbps_rot_cordic import fbps_pkg::*;
(
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [ANG_IN_W-1:0] crank_angle,
    input  logic        [LEN_W-1:0]    crank_length,
    output logic signed [ROT_W-1:0]    x,
    output logic signed [ROT_W-1:0]    y
);

    logic signed [ANG_IN_W:0] a;
    logic signed [ANG_IN_W:0] r_reg;
    logic [53:0]              p;
    logic [53:0]              p_reg;

    assign a = (ANG_IN_W+1)'(crank_angle);
    assign p = {crank_length, 8'h00} * GAIN_Q30;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p;
            if (a > HALF_UNITS)
                r_reg <= a - (ANG_IN_W+1)'(TURN_UNITS);
            else if (a <= -HALF_UNITS)
                r_reg <= a + (ANG_IN_W+1)'(TURN_UNITS);
            else
                r_reg <= a;
        end
    end

    logic signed [ROT_W-1:0]  xv_reg [CORDIC_STEPS+1];
    logic signed [ROT_W-1:0]  yv_reg [CORDIC_STEPS+1];
    logic signed [ROTZ_W-1:0] zv_reg [CORDIC_STEPS+1];
    logic [53:0]              pr;
    logic signed [ROT_W-1:0]  x0;

    assign pr = p_reg + 54'(1 << 29);
    assign x0 = $signed({3'b000, pr[53:30]});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yv_reg[0] <= '0;
            if (r_reg > QUARTER_UNITS)
            begin
                xv_reg[0] <= -x0;
                zv_reg[0] <= ROTZ_W'(r_reg - (ANG_IN_W+1)'(HALF_UNITS)) <<< ANG_FRAC;
            end
            else if (r_reg < -QUARTER_UNITS)
            begin
                xv_reg[0] <= -x0;
                zv_reg[0] <= ROTZ_W'(r_reg + (ANG_IN_W+1)'(HALF_UNITS)) <<< ANG_FRAC;
            end
            else
            begin
                xv_reg[0] <= x0;
                zv_reg[0] <= ROTZ_W'(r_reg) <<< ANG_FRAC;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic signed [ROT_W-1:0]  xs;
        logic signed [ROT_W-1:0]  ys;
        logic signed [ROTZ_W-1:0] at;
        assign xs = xv_reg[i] >>> i;
        assign ys = yv_reg[i] >>> i;
        assign at = ROTZ_W'(ATAN_TABLE[i]);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (zv_reg[i] >= 0)
                begin
                    xv_reg[i+1] <= xv_reg[i] - ys;
                    yv_reg[i+1] <= yv_reg[i] + xs;
                    zv_reg[i+1] <= zv_reg[i] - at;
                end
                else
                begin
                    xv_reg[i+1] <= xv_reg[i] + ys;
                    yv_reg[i+1] <= yv_reg[i] - xs;
                    zv_reg[i+1] <= zv_reg[i] + at;
                end
            end
        end
    end

    assign x = xv_reg[CORDIC_STEPS];
    assign y = yv_reg[CORDIC_STEPS];

endmodule

// ===== design/four_bar_position_solver.sv =====
// Four-bar position solver top: config registers, distance, closure checks, output stage.
// Throughput one transfer per cycle; the whole pipeline holds while a result is stalled.
// rst_n clears the valid pipeline and loads the register reset values; data needs no reset.
// Depends on fbps_pkg, fbps_rot_cordic, fbps_isqrt, fbps_acos, fbps_vec_cordic.
`include "assert_macros.svh"
module four_bar_position_solver import fbps_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [LEN_W-1:0]           cfg_data,
    input  logic                       crank_valid,
    output logic                       crank_stall,
    input  logic signed [ANG_IN_W-1:0] crank_angle,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic signed [ANG_IN_W-1:0] rocker_angle,
    output logic [TRANS_W-1:0]         transmission_angle,
    output logic [STATUS_W-1:0]        status
);

    logic [LEN_W-1:0] crank_reg;
    logic [LEN_W-1:0] coupler_reg;
    logic [LEN_W-1:0] rocker_reg;
    logic [LEN_W-1:0] frame_reg;
    logic [LEN_W-1:0] tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crank_reg   <= '0;
            coupler_reg <= '0;
            rocker_reg  <= '0;
            frame_reg   <= '0;
            tol_reg     <= LEN_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_CRANK:   crank_reg   <= cfg_data;
                CFG_COUPLER: coupler_reg <= cfg_data;
                CFG_ROCKER:  rocker_reg  <= cfg_data;
                CFG_FRAME:   frame_reg   <= cfg_data;
                CFG_TOL:     tol_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    logic en;
    logic valid_reg [TOTAL_LAT];

    assign en           = !(valid_reg[TOTAL_LAT-1] && result_stall);
    assign crank_stall  = !en;
    assign result_valid = valid_reg[TOTAL_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TOTAL_LAT; i++)
                valid_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= crank_valid;
            for (int i = 1; i < TOTAL_LAT; i++)
                valid_reg[i] <= valid_reg[i-1];
        end
    end

    logic signed [ROT_W-1:0] x_rot;
    logic signed [ROT_W-1:0] y_rot;

    fbps_rot_cordic u_rot
    (
        .clk          (clk),
        .en           (en),
        .crank_angle  (crank_angle),
        .crank_length (crank_reg),
        .x            (x_rot),
        .y            (y_rot)
    );

    logic signed [ROT_W-1:0]   dx_reg;
    logic signed [ROT_W-1:0]   dy_reg;
    logic signed [2*ROT_W-1:0] sqx;
    logic signed [2*ROT_W-1:0] sqy;
    logic [51:0]               sqx_reg;
    logic [51:0]               sqy_reg;
    logic [RAD_W-1:0]          sum_reg;
    logic [ROOT_W-1:0]         root;

    assign sqx = dx_reg * dx_reg;
    assign sqy = dy_reg * dy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg  <= $signed({3'b000, frame_reg, 8'h00}) - x_rot;
            dy_reg  <= -y_rot;
            sqx_reg <= sqx[51:0];
            sqy_reg <= sqy[51:0];
            sum_reg <= RAD_W'(sqx_reg) + RAD_W'(sqy_reg);
        end
    end

    fbps_isqrt u_dist
    (
        .clk (clk),
        .en  (en),
        .n   (sum_reg),
        .q   (root)
    );

    logic [D_W-1:0]   d;
    logic [23:0]      l2;
    logic [23:0]      l3;
    logic [23:0]      tol;
    logic [24:0]      lsum;
    logic [23:0]      ldiff;
    logic [47:0]      l2sq;
    logic [47:0]      l3sq;
    logic [2*D_W-1:0] dsq;
    logic [47:0]      l2l3;
    logic [49:0]      l3d;

    assign d     = root[D_W-1:0];
    assign l2    = {coupler_reg, 8'h00};
    assign l3    = {rocker_reg, 8'h00};
    assign tol   = {tol_reg, 8'h00};
    assign lsum  = 25'(l2) + 25'(l3);
    assign ldiff = (l2 > l3) ? (l2 - l3) : (l3 - l2);
    assign l2sq  = l2 * l2;
    assign l3sq  = l3 * l3;
    assign dsq   = d * d;
    assign l2l3  = l2 * l3;
    assign l3d   = l3 * d;

    logic [47:0]      l2sq_reg;
    logic [47:0]      l3sq_reg;
    logic [2*D_W-1:0] dsq_reg;
    logic [DEN_W-1:0] dent_reg;
    logic [DEN_W-1:0] dena_reg;
    logic             deg_reg;
    logic             unr_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l2sq_reg <= l2sq;
            l3sq_reg <= l3sq;
            dsq_reg  <= dsq;
            dent_reg <= DEN_W'({l2l3, 1'b0});
            dena_reg <= DEN_W'({l3d, 1'b0});
            deg_reg  <= (26'(tol) > d) || (d == '0) || (coupler_reg == '0)
                        || (rocker_reg == '0);
            unr_reg  <= (26'(lsum) < d) || (26'(ldiff) > d);
        end
    end

    logic signed [NUM_W-1:0] numt_reg;
    logic signed [NUM_W-1:0] numa_reg;
    logic [DEN_W-1:0]        dent2_reg;
    logic [DEN_W-1:0]        dena2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            numt_reg  <= $signed(NUM_W'(l2sq_reg) + NUM_W'(l3sq_reg) - NUM_W'(dsq_reg));
            numa_reg  <= $signed(NUM_W'(l3sq_reg) + NUM_W'(dsq_reg) - NUM_W'(l2sq_reg));
            dent2_reg <= dent_reg;
            dena2_reg <= dena_reg;
        end
    end

    logic signed [ANG_W-1:0] zt;
    logic signed [ANG_W-1:0] za;
    logic signed [ANG_W-1:0] zb;

    fbps_acos u_trans
    (
        .clk (clk),
        .en  (en),
        .num (numt_reg),
        .den (dent2_reg),
        .z   (zt)
    );

    fbps_acos u_alpha
    (
        .clk (clk),
        .en  (en),
        .num (numa_reg),
        .den (dena2_reg),
        .z   (za)
    );

    logic signed [ROT_W-1:0] dxd_reg [BETA_DLY];
    logic signed [ROT_W-1:0] dyd_reg [BETA_DLY];
    logic                    degd_reg [FLAG_DLY];
    logic                    unrd_reg [FLAG_DLY];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dxd_reg[0] <= dx_reg;
            dyd_reg[0] <= dy_reg;
            for (int i = 1; i < BETA_DLY; i++)
            begin
                dxd_reg[i] <= dxd_reg[i-1];
                dyd_reg[i] <= dyd_reg[i-1];
            end
            degd_reg[0] <= deg_reg;
            unrd_reg[0] <= unr_reg;
            for (int i = 1; i < FLAG_DLY; i++)
            begin
                degd_reg[i] <= degd_reg[i-1];
                unrd_reg[i] <= unrd_reg[i-1];
            end
        end
    end

    fbps_vec_cordic u_beta
    (
        .clk (clk),
        .en  (en),
        .y   (VIN_W'(dyd_reg[BETA_DLY-1])),
        .x   (VIN_W'(dxd_reg[BETA_DLY-1])),
        .z   (zb)
    );

    logic signed [ANG_W-1:0] tr;
    logic signed [ANG_W:0]   rk;
    logic [TRANS_W-1:0]      trans_next;
    logic signed [ANG_IN_W-1:0] rocker_next;
    logic [STATUS_W-1:0]     status_next;
    logic                    deg;

    assign deg = degd_reg[FLAG_DLY-1];
    assign tr  = (zt + ANG_W'(1 << (ANG_FRAC - 1))) >>> ANG_FRAC;
    assign rk  = ((ANG_W+1)'(zb) + (ANG_W+1)'(za) + (ANG_W+1)'(1 << (ANG_FRAC - 1)))
                 >>> ANG_FRAC;

    always_comb
    begin
        if (deg || tr < 0)
            trans_next = '0;
        else if (tr > HALF_UNITS)
            trans_next = TRANS_W'(HALF_UNITS);
        else
            trans_next = tr[TRANS_W-1:0];
        rocker_next = '0;
        if (frame_reg < tol_reg)
            status_next = ST_FRAME;
        else if (unrd_reg[FLAG_DLY-1])
            status_next = ST_UNREACH;
        else if (deg)
            status_next = ST_DEGEN;
        else
        begin
            status_next = ST_OK;
            rocker_next = rk[ANG_IN_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rocker_angle       <= rocker_next;
            transmission_angle <= trans_next;
            status             <= status_next;
        end
    end

    `CHECK_IMPLY(a_rocker_zero, result_valid && status != ST_OK, rocker_angle == '0)
    `CHECK_IMPLY(a_degen_trans, result_valid && status == ST_DEGEN, transmission_angle == '0)
    `CHECK_IMPLY(a_trans_range, result_valid, transmission_angle <= TRANS_W'(HALF_UNITS))
    `CHECK_NEXT(a_drain, result_valid && !result_stall && !valid_reg[TOTAL_LAT-2], !result_valid)

endmodule
